FILE: rtl/cpbe_pkg.sv
package cpbe_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_MODE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RANGES = 1'b1;

  typedef enum logic [1:0] {
    MODE_UTF8  = 2'd0,
    MODE_UCS2  = 2'd1,
    MODE_RANGE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SCAN,
    FE_DONE
  } fe_state_e;

  localparam logic [30:0] Utf8Max1 = 31'h0000007f;
  localparam logic [30:0] Utf8Max2 = 31'h000007ff;
  localparam logic [30:0] Utf8Max3 = 31'h0000ffff;
  localparam logic [30:0] Utf8Max4 = 31'h0010ffff;
  localparam logic [30:0] Ucs2Max  = 31'h0000ffff;

  localparam logic [2:0] MaxBytes = 3'd4;

  typedef struct packed {
    logic        func;
    logic [30:0] code_point;
    logic [3:0]  room;
    logic [5:0]  entry_index;
    logic [20:0] entry_first;
    logic [20:0] entry_last;
    logic [31:0] entry_out;
    logic [2:0]  entry_bytes;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       ok;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [20:0] first;
    logic [20:0] last;
    logic [31:0] out;
    logic [2:0]  bytes;
  } entry_t;

  // A count of zero marks an item that failed.
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  count;
  } job_t;

endpackage

FILE: rtl/cpbe_front.sv
module cpbe_front #(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpbe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpbe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  cpbe_pkg::in_item_t            in_item_i,
  output logic                          q_push_o,
  input  logic                          q_full_i,
  output cpbe_pkg::job_t                q_job_o
);

  localparam int unsigned AddrW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_RANGES + 1);

  logic [1:0]                 mode_q;
  logic [6:0]                 ranges_q;
  logic [CntW-1:0]            limit;
  cpbe_pkg::fe_state_e        state_q, state_d;
  logic [CntW-1:0]            idx_q, idx_d, next_idx;
  logic [30:0]                c_q;
  logic [3:0]                 room_q;
  logic [31:0]                hit_out_q;
  logic [31:0]                hit_diff_q;
  logic [2:0]                 cnt_q;
  cpbe_pkg::entry_t           mem [MAX_RANGES];
  cpbe_pkg::entry_t           rd_q;
  logic                       rd_en;
  logic [AddrW-1:0]           rd_addr;
  logic                       wr_en;
  logic                       accept;
  logic                       index_ok;
  logic                       hit;
  logic                       bad;
  logic [31:0]                enc_v;
  logic [2:0]                 enc_n;

  assign limit = (32'(ranges_q) > MAX_RANGES) ? CntW'(MAX_RANGES) : CntW'(ranges_q);
  assign full_o   = (state_q != cpbe_pkg::FE_IDLE) || q_full_i;
  assign accept   = push_i && !full_o;
  assign index_ok = 32'(in_item_i.entry_index) < MAX_RANGES;
  assign next_idx = idx_q + 1'b1;

  assign hit = (31'(rd_q.first) <= c_q) && (c_q <= 31'(rd_q.last));
  assign bad = (rd_q.bytes == 3'd0) || (rd_q.bytes > cpbe_pkg::MaxBytes) ||
               (room_q < {1'b0, rd_q.bytes});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'd0;
      ranges_q <= 7'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpbe_pkg::CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        cpbe_pkg::CFG_RANGES: ranges_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [30:0] c;
    logic [3:0]  r;
    c     = in_item_i.code_point;
    r     = in_item_i.room;
    enc_v = 32'd0;
    enc_n = 3'd0;
    case (mode_q)
      cpbe_pkg::MODE_UTF8: begin
        if (c <= cpbe_pkg::Utf8Max1) begin
          enc_v = {25'd0, c[6:0]};
          enc_n = (r < 4'd1) ? 3'd0 : 3'd1;
        end else if (c <= cpbe_pkg::Utf8Max2) begin
          enc_v = {16'd0, 3'b110, c[10:6], 2'b10, c[5:0]};
          enc_n = (r < 4'd2) ? 3'd0 : 3'd2;
        end else if (c <= cpbe_pkg::Utf8Max3) begin
          enc_v = {8'd0, 4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0]};
          enc_n = (r < 4'd3) ? 3'd0 : 3'd3;
        end else if (c <= cpbe_pkg::Utf8Max4) begin
          enc_v = {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0]};
          enc_n = (r < 4'd4) ? 3'd0 : 3'd4;
        end
      end
      cpbe_pkg::MODE_UCS2: begin
        enc_v = {16'd0, c[15:0]};
        enc_n = ((c > cpbe_pkg::Ucs2Max) || (r < 4'd2)) ? 3'd0 : 3'd2;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    q_push_o = 1'b0;
    q_job_o  = '{value: enc_v, count: enc_n};
    case (state_q)
      cpbe_pkg::FE_IDLE: begin
        if (accept) begin
          if (in_item_i.func) begin
            wr_en = index_ok;
          end else if ((mode_q == cpbe_pkg::MODE_RANGE) && (limit != '0)) begin
            rd_en   = 1'b1;
            idx_d   = '0;
            state_d = cpbe_pkg::FE_SCAN;
          end else begin
            q_push_o = 1'b1;
          end
        end
      end
      cpbe_pkg::FE_SCAN: begin
        if (hit || (next_idx == limit)) begin
          state_d = cpbe_pkg::FE_DONE;
        end else begin
          idx_d   = next_idx;
          rd_en   = 1'b1;
          rd_addr = next_idx[AddrW-1:0];
        end
      end
      cpbe_pkg::FE_DONE: begin
        q_job_o = '{value: hit_out_q + hit_diff_q, count: cnt_q};
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = cpbe_pkg::FE_IDLE;
        end
      end
      default: state_d = cpbe_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpbe_pkg::FE_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q    <= in_item_i.code_point;
      room_q <= in_item_i.room;
    end
    if (state_q == cpbe_pkg::FE_SCAN) begin
      hit_out_q  <= rd_q.out;
      hit_diff_q <= 32'(c_q) - 32'(rd_q.first);
      cnt_q      <= (hit && !bad) ? rd_q.bytes : 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AddrW'(in_item_i.entry_index)] <= '{first: in_item_i.entry_first,
                                              last:  in_item_i.entry_last,
                                              out:   in_item_i.entry_out,
                                              bytes: in_item_i.entry_bytes};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/cpbe_queue.sv
module cpbe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpbe_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cpbe_pkg::job_t job_o
);

  cpbe_pkg::job_t slot_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push;
  logic           do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: rtl/cpbe_back.sv
module cpbe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                q_pop_o,
  input  logic                q_empty_i,
  input  cpbe_pkg::job_t      q_job_i,
  output logic                empty_o,
  input  logic                pop_i,
  output cpbe_pkg::out_item_t out_item_o
);

  logic                job_valid_q;
  logic [31:0]         value_q;
  logic [2:0]          rem_q;
  logic                out_valid_q;
  cpbe_pkg::out_item_t out_q;
  logic                load_out;
  logic                job_done;
  logic [7:0]          sel_byte;
  cpbe_pkg::out_item_t next_out;

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;
  assign q_pop_o    = !job_valid_q && !q_empty_i;
  assign load_out   = job_valid_q && (!out_valid_q || pop_i);
  assign job_done   = (rem_q == 3'd0) || (rem_q == 3'd1);

  always_comb begin
    case (rem_q)
      3'd1:    sel_byte = value_q[7:0];
      3'd2:    sel_byte = value_q[15:8];
      3'd3:    sel_byte = value_q[23:16];
      3'd4:    sel_byte = value_q[31:24];
      default: sel_byte = 8'd0;
    endcase
    if (rem_q == 3'd0) begin
      next_out = '{out_byte: 8'd0, ok: 1'b0, last_byte: 1'b1};
    end else begin
      next_out = '{out_byte: sel_byte, ok: 1'b1, last_byte: rem_q == 3'd1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        job_valid_q <= 1'b1;
      end else if (load_out && job_done) begin
        job_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      value_q <= q_job_i.value;
      rem_q   <= q_job_i.count;
    end else if (load_out) begin
      rem_q <= job_done ? 3'd0 : rem_q - 3'd1;
    end
    if (load_out) begin
      out_q <= next_out;
    end
  end

endmodule

FILE: rtl/code_point_byte_encoder_top.sv
// Channel  | Ports                                  | Moves
// ---------+----------------------------------------+---------------------------------
// input    | push, full, in_item_i                  | one code point or table entry
// result   | empty, pop, out_item_o                 | one encoded byte per item taken
// config   | cfg_we_i, cfg_idx_i, cfg_data_i        | encoding_mode, ranges_in_use
//
// A UTF-8 or UCS-2 item goes to the queue at the edge that takes it. With the back end idle,
// its first byte passes the queue slot, the back end's job register and its output register on
// its way out, the rest follow one per cycle while popped, and the back end takes the next job
// only after loading the last byte of the current one. In range mode the front end reads the
// table memory one entry per cycle, so full stays high until the search result is queued.
// Reset clears only control state; table entries hold nothing until written.
// Two jobs can wait in the queue behind a held result, after which full stays high.
module code_point_byte_encoder_top #(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpbe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpbe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  cpbe_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output cpbe_pkg::out_item_t           out_item_o
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  cpbe_pkg::job_t job_in;
  cpbe_pkg::job_t job_out;

  cpbe_front #(
    .MAX_RANGES(MAX_RANGES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .q_push_o   (q_push),
    .q_full_i   (q_full),
    .q_job_o    (job_in)
  );

  cpbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  cpbe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_pop_o    (q_pop),
    .q_empty_i  (q_empty),
    .q_job_i    (job_out),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("Front end pushed a job into a full queue.");

  a_fail_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.ok) |-> (out_item_o.last_byte && (out_item_o.out_byte == 8'd0)))
    else $error("Failure result is not a single zero byte.");

  a_bytes_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_item_o.last_byte) |=> !empty)
    else $error("Next byte of an item did not follow a taken byte.");
`endif

endmodule

FILE: dv/code_point_byte_encoder_top_tb.sv
`timescale 1ns / 1ps

module code_point_byte_encoder_top_tb;

  localparam int unsigned MaxRanges = 64;
  localparam int unsigned SettleCycles = MaxRanges + 16;
  localparam int unsigned LongHold = 300;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0] ModeUndef = 2'd3;
  localparam logic [7:0] Lead2 = 8'hc0;
  localparam logic [7:0] Lead3 = 8'he0;
  localparam logic [7:0] Lead4 = 8'hf0;
  localparam logic [7:0] ContMark = 8'h80;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [cpbe_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [cpbe_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          push;
  logic                          full;
  cpbe_pkg::in_item_t            char_in;
  logic                          empty;
  logic                          pop;
  cpbe_pkg::out_item_t           byte_out;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_requests;
  int          hold_done;
  int unsigned cycles;
  int unsigned border_codes [9] = '{32'h0, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hffff,
                                    32'h10000, 32'h10ffff, 32'h110000};

  class byte_tracker;
    logic [1:0]          mode;
    logic [6:0]          ranges;
    cpbe_pkg::entry_t    tab [MaxRanges];
    cpbe_pkg::out_item_t bytes_due [$];
    int                  errors;
    int                  items_seen;
    int                  bytes_seen;

    function new();
      mode = cpbe_pkg::MODE_UTF8;
      ranges = '0;
      errors = 0;
      items_seen = 0;
      bytes_seen = 0;
    endfunction

    function void set_reg(logic [cpbe_pkg::CfgIdxW-1:0] idx,
                          logic [cpbe_pkg::CfgDataW-1:0] data);
      if (idx == cpbe_pkg::CFG_MODE) begin
        mode = data[1:0];
      end else begin
        ranges = data[6:0];
      end
    endfunction

    // Returns the byte count, zero on failure; the bytes sit right-aligned in word.
    function int encode_char(input cpbe_pkg::in_item_t it, output logic [31:0] word);
      int          need;
      int          lim;
      bit          hit;
      logic [30:0] c;
      need = 0;
      word = '0;
      hit = 1'b0;
      c = it.code_point;
      if (mode == cpbe_pkg::MODE_UTF8) begin
        if (c <= cpbe_pkg::Utf8Max1) begin
          need = 1;
          word = {24'h0, 1'b0, c[6:0]};
        end else if (c <= cpbe_pkg::Utf8Max2) begin
          need = 2;
          word = {16'h0, Lead2 | 8'(c[10:6]), ContMark | 8'(c[5:0])};
        end else if (c <= cpbe_pkg::Utf8Max3) begin
          need = 3;
          word = {8'h0, Lead3 | 8'(c[15:12]), ContMark | 8'(c[11:6]), ContMark | 8'(c[5:0])};
        end else if (c <= cpbe_pkg::Utf8Max4) begin
          need = 4;
          word = {Lead4 | 8'(c[20:18]), ContMark | 8'(c[17:12]), ContMark | 8'(c[11:6]),
                  ContMark | 8'(c[5:0])};
        end
      end else if (mode == cpbe_pkg::MODE_UCS2) begin
        if (c <= cpbe_pkg::Ucs2Max) begin
          need = 2;
          word = {16'h0, c[15:0]};
        end
      end else if (mode == cpbe_pkg::MODE_RANGE) begin
        lim = (ranges > MaxRanges) ? MaxRanges : int'(ranges);
        for (int i = 0; i < lim && !hit; i++) begin
          if (31'(tab[i].first) <= c && c <= 31'(tab[i].last)) begin
            hit = 1'b1;
            need = (tab[i].bytes > cpbe_pkg::MaxBytes) ? 0 : int'(tab[i].bytes);
            word = tab[i].out + 32'(c) - 32'(tab[i].first);
          end
        end
      end
      if (int'(it.room) < need) need = 0;
      return need;
    endfunction

    function void take_char(cpbe_pkg::in_item_t it);
      logic [31:0]         word;
      int                  n;
      cpbe_pkg::out_item_t r;
      items_seen++;
      if (it.func) begin
        tab[it.entry_index] = '{first: it.entry_first, last: it.entry_last,
                                out: it.entry_out, bytes: it.entry_bytes};
        return;
      end
      n = encode_char(it, word);
      if (n == 0) begin
        r = '{out_byte: 8'h00, ok: 1'b0, last_byte: 1'b1};
        bytes_due.insert(bytes_due.size(), r);
      end else begin
        for (int k = 0; k < n; k++) begin
          r.out_byte = word[8*(n-1-k) +: 8];
          r.ok = 1'b1;
          r.last_byte = (k == n - 1);
          bytes_due.insert(bytes_due.size(), r);
        end
      end
    endfunction

    function void check_byte(cpbe_pkg::out_item_t got);
      cpbe_pkg::out_item_t want;
      bytes_seen++;
      if (bytes_due.size() == 0) begin
        $error("unexpected item: out_byte %02h ok %0b last_byte %0b",
               got.out_byte, got.ok, got.last_byte);
        errors++;
        return;
      end
      want = bytes_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte expected %02h actual %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("ok expected %0b actual %0b", want.ok, got.ok);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte expected %0b actual %0b", want.last_byte, got.last_byte);
        errors++;
      end
    endfunction
  endclass

  byte_tracker sb = new();

  code_point_byte_encoder_top #(
    .MAX_RANGES(MaxRanges)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_item_i  (char_in),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (byte_out)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_byte(byte_out);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_done != hold_requests) begin
        pop = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_done++;
      end
      pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic cpbe_pkg::in_item_t noise_item();
    cpbe_pkg::in_item_t it;
    it.func = 1'b0;
    it.code_point = 31'($urandom);
    it.room = 4'($urandom);
    it.entry_index = 6'($urandom);
    it.entry_first = 21'($urandom_range(32'h10ffff));
    it.entry_last = 21'($urandom_range(32'h10ffff));
    it.entry_out = $urandom;
    it.entry_bytes = 3'($urandom);
    return it;
  endfunction

  function automatic cpbe_pkg::in_item_t char_item(int unsigned code, int unsigned room_b);
    cpbe_pkg::in_item_t it;
    it = noise_item();
    it.code_point = 31'(code);
    it.room = 4'(room_b);
    return it;
  endfunction

  function automatic cpbe_pkg::in_item_t fixed_entry(int unsigned idx, int unsigned first,
                                                     int unsigned last, int unsigned out,
                                                     int unsigned bytes);
    cpbe_pkg::in_item_t it;
    it = noise_item();
    it.func = 1'b1;
    it.entry_index = 6'(idx);
    it.entry_first = 21'(first);
    it.entry_last = 21'(last);
    it.entry_out = out;
    it.entry_bytes = 3'(bytes);
    return it;
  endfunction

  function automatic cpbe_pkg::in_item_t table_entry(int unsigned idx);
    int unsigned first;
    int unsigned last;
    int unsigned bytes;
    first = ($urandom_range(3) == 0) ? $urandom_range(32'h10ffff) : $urandom_range(4095);
    case ($urandom_range(9))
      0, 1:    last = first;
      2:       last = (first > 0) ? first - 1 : first;
      3:       last = first + $urandom_range(4000);
      default: last = first + $urandom_range(63);
    endcase
    if (last > 32'h10ffff) last = 32'h10ffff;
    bytes = ($urandom_range(6) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
    return fixed_entry(idx, first, last, $urandom, bytes);
  endfunction

  function automatic int unsigned utf8_code();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(127);
      2:       return $urandom_range(32'h7ff, 32'h80);
      3:       return $urandom_range(32'hffff, 32'h800);
      4:       return $urandom_range(32'hdfff, 32'hd800);
      5, 6:    return $urandom_range(32'h10ffff, 32'h10000);
      7:       return border_codes[$urandom_range(8)];
      8:       return $urandom_range(32'h7fffffff, 32'h110000);
      default: return $urandom & 32'h7fffffff;
    endcase
  endfunction

  function automatic int unsigned range_code();
    int               lim;
    int               j;
    cpbe_pkg::entry_t e;
    lim = (sb.ranges > MaxRanges) ? MaxRanges : int'(sb.ranges);
    if (lim > 0 && $urandom_range(3) != 0) begin
      j = $urandom_range(lim - 1);
      e = sb.tab[j];
      if (e.first <= e.last) return e.first + $urandom_range(32'(e.last - e.first));
    end
    return $urandom_range(1) ? $urandom_range(32'h10ffff) : ($urandom & 32'h7fffffff);
  endfunction

  function automatic int unsigned room_pick();
    return ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(15, 4);
  endfunction

  task automatic send_item(input cpbe_pkg::in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    char_in = it;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    sb.take_char(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [cpbe_pkg::CfgIdxW-1:0] idx,
                           input int unsigned value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = cpbe_pkg::CfgDataW'(value);
    sb.set_reg(idx, cpbe_pkg::CfgDataW'(value));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] mode, input int unsigned ranges,
                           input int count, input int write_pct);
    int unsigned code;
    drain();
    cfg_write(cpbe_pkg::CFG_MODE, mode);
    cfg_write(cpbe_pkg::CFG_RANGES, ranges);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < write_pct) begin
        send_item(table_entry($urandom_range(MaxRanges - 1)));
      end else begin
        case (mode)
          cpbe_pkg::MODE_UCS2: begin
            code = ($urandom_range(9) < 7) ? $urandom_range(32'hffff) : utf8_code();
          end
          cpbe_pkg::MODE_RANGE: code = range_code();
          default:              code = utf8_code();
        endcase
        send_item(char_item(code, room_pick()));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = cpbe_pkg::CFG_MODE;
    cfg_data_i = '0;
    char_in = '0;
    cycles = 0;
    hold_requests = 0;
    hold_done = 0;
    send_idle_pct = 12;
    recv_idle_pct = 62;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(cpbe_pkg::CFG_MODE, cpbe_pkg::MODE_UTF8);
    cfg_write(cpbe_pkg::CFG_RANGES, 0);
    send_item(char_item(32'h0, 1));
    send_item(char_item(32'h7f, 1));
    send_item(char_item(32'h7f, 0));
    send_item(char_item(32'h80, 2));
    send_item(char_item(32'h7ff, 2));
    send_item(char_item(32'h800, 2));
    send_item(char_item(32'hffff, 3));
    send_item(char_item(32'hd800, 3));
    send_item(char_item(32'h10000, 4));
    send_item(char_item(32'h10ffff, 15));
    send_item(char_item(32'h110000, 15));
    send_item(char_item(32'h7fffffff, 15));

    // Every entry is loaded before any range search can touch it.
    for (int i = 0; i < MaxRanges; i++) send_item(table_entry(i));
    send_item(fixed_entry(0, 32'h41, 32'h41, 32'h12345678, 2));
    send_item(fixed_entry(1, 32'h100, 32'h1ff, 32'ha1b2c3d4, 4));
    send_item(fixed_entry(2, 32'h300, 32'h3ff, 32'h55, 7));
    send_item(fixed_entry(3, 32'h100, 32'h10ffff, 32'h0, 1));

    drain();
    cfg_write(cpbe_pkg::CFG_MODE, cpbe_pkg::MODE_RANGE);
    cfg_write(cpbe_pkg::CFG_RANGES, 4);
    send_item(char_item(32'h41, 2));
    send_item(char_item(32'h41, 1));
    send_item(char_item(32'h150, 4));
    send_item(char_item(32'h350, 15));
    send_item(char_item(32'h600, 1));
    send_item(char_item(32'h20, 15));
    drain();
    cfg_write(cpbe_pkg::CFG_RANGES, 0);
    send_item(char_item(32'h41, 15));
    drain();
    cfg_write(cpbe_pkg::CFG_RANGES, 127);
    send_item(char_item(32'h41, 15));
    drain();
    cfg_write(cpbe_pkg::CFG_MODE, ModeUndef);
    send_item(char_item(32'h41, 15));

    run_phase(cpbe_pkg::MODE_UTF8, 0, 40, 10);
    drain();
    cfg_write(cpbe_pkg::CFG_MODE, cpbe_pkg::MODE_RANGE);
    cfg_write(cpbe_pkg::CFG_RANGES, MaxRanges);
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(99) < 10) begin
        send_item(table_entry($urandom_range(MaxRanges - 1)));
      end else begin
        send_item(char_item(range_code(), room_pick()));
      end
    end

    drain();
    send_idle_pct = 62;
    recv_idle_pct = 12;
    run_phase(cpbe_pkg::MODE_UCS2, 5, 40, 10);
    run_phase(cpbe_pkg::MODE_RANGE, 1, 30, 15);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(cpbe_pkg::MODE_RANGE, 127, 30, 10);
    run_phase(ModeUndef, 17, 20, 10);
    run_phase(cpbe_pkg::MODE_UTF8, 0, 30, 5);
    drain();

    $display("Covered UTF-8, UCS-2, range-table and undefined modes with table rewrites,");
    $display("%0d items in and %0d result bytes checked.", sb.items_seen, sb.bytes_seen);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cpbe_pkg.sv
rtl/cpbe_front.sv
rtl/cpbe_queue.sv
rtl/cpbe_back.sv
rtl/code_point_byte_encoder_top.sv
dv/code_point_byte_encoder_top_tb.sv
